// ===== sv/milage_pkg.sv =====
package milage_pkg;

   localparam logic [63:0] OPC_HI_RESET = 64'hb0f81a46608e80b2;
   localparam logic [63:0] OPC_LO_RESET = 64'h2a3023e00a396fd7;
   localparam int unsigned ROUNDS = 10;
   localparam int unsigned LANES = 5;

   localparam logic CSR_OPC_HI = 1'b0;
   localparam logic CSR_OPC_LO = 1'b1;

   // state and key words as they travel down the chain
   typedef logic [127:0] block_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] b);
      xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] rcon_of(input logic [3:0] r);
      logic [7:0] v;
      v = 8'h01;
      for (int i = 1; i < 10; i++) begin
         if (i < int'(r)) v = xtime(v);
      end
      rcon_of = v;
   endfunction

   // byte 0 sits at bits 127:120
   function automatic logic [7:0] byte_at(input block_type b, input int i);
      byte_at = b[127 - 8*i -: 8];
   endfunction

   function automatic block_type next_key(input block_type k, input logic [7:0] rc);
      logic [31:0] w [4];
      logic [31:0] t;
      for (int i = 0; i < 4; i++) w[i] = k[127 - 32*i -: 32];
      t = {SBOX[w[3][23:16]] ^ rc, SBOX[w[3][15:8]], SBOX[w[3][7:0]], SBOX[w[3][31:24]]};
      w[0] = w[0] ^ t;
      w[1] = w[1] ^ w[0];
      w[2] = w[2] ^ w[1];
      w[3] = w[3] ^ w[2];
      next_key = {w[0], w[1], w[2], w[3]};
   endfunction

   function automatic block_type aes_round(input block_type s, input logic last);
      logic [7:0] t [16];
      logic [7:0] a, b, c, d, all;
      block_type o;
      for (int col = 0; col < 4; col++)
         for (int row = 0; row < 4; row++)
            t[4*col + row] = SBOX[byte_at(s, 4*((col + row) & 3) + row)];
      if (!last) begin
         for (int col = 0; col < 4; col++) begin
            a = t[4*col]; b = t[4*col+1]; c = t[4*col+2]; d = t[4*col+3];
            all = a ^ b ^ c ^ d;
            t[4*col]   = a ^ all ^ xtime(a ^ b);
            t[4*col+1] = b ^ all ^ xtime(b ^ c);
            t[4*col+2] = c ^ all ^ xtime(c ^ d);
            t[4*col+3] = d ^ all ^ xtime(d ^ a);
         end
      end
      for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = t[i];
      aes_round = o;
   endfunction

endpackage

// ===== sv/milage_cell.sv =====
// One AES round: carries several lanes of state plus the round key and
// the side words that travel with the item.
module milage_cell #(
   parameter int unsigned NLANES = milage_pkg::LANES,
   parameter int unsigned SIDEW = 1,
   parameter logic [3:0] RND = 4'd1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  milage_pkg::block_type              in_key,
   input  milage_pkg::block_type [NLANES-1:0] in_state,
   input  logic [SIDEW-1:0]                   in_side,
   output logic                               out_valid,
   output milage_pkg::block_type              out_key,
   output milage_pkg::block_type [NLANES-1:0] out_state,
   output logic [SIDEW-1:0]                   out_side
);
   logic valid_ff;
   milage_pkg::block_type key_ff, key_in;
   milage_pkg::block_type [NLANES-1:0] state_ff, state_in;
   logic [SIDEW-1:0] side_ff;

   // round key and round function for every lane
   always_comb begin
      key_in = milage_pkg::next_key(in_key, milage_pkg::rcon_of(RND));
      for (int l = 0; l < NLANES; l++)
         state_in[l] = milage_pkg::aes_round(in_state[l], RND == 4'd10) ^ key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= in_valid;
      key_ff   <= key_in;
      state_ff <= state_in;
      side_ff  <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_key   = key_ff;
   assign out_state = state_ff;
   assign out_side  = side_ff;
endmodule

// ===== sv/milage_chain.sv =====
// Ten round cells in a row: one full AES-128 over NLANES blocks.
module milage_chain #(
   parameter int unsigned NLANES = milage_pkg::LANES,
   parameter int unsigned SIDEW = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  milage_pkg::block_type              in_key,
   input  milage_pkg::block_type [NLANES-1:0] in_block,
   input  logic [SIDEW-1:0]                   in_side,
   output logic                               out_valid,
   output milage_pkg::block_type              out_key,
   output milage_pkg::block_type [NLANES-1:0] out_block,
   output logic [SIDEW-1:0]                   out_side
);
   localparam int unsigned N = milage_pkg::ROUNDS;
   logic                               v   [N+1];
   milage_pkg::block_type              k   [N+1];
   milage_pkg::block_type [NLANES-1:0] s   [N+1];
   logic [SIDEW-1:0]                   sd  [N+1];

   // initial whitening
   assign v[0]  = in_valid;
   assign k[0]  = in_key;
   assign sd[0] = in_side;
   assign s[0]  = in_block ^ {NLANES{in_key}};

   for (genvar g = 0; g < N; g++) begin : g_round
      milage_cell #(.NLANES(NLANES), .SIDEW(SIDEW), .RND(4'(g + 1))) u_cell (
         .clock(clock), .reset(reset),
         .in_valid(v[g]), .in_key(k[g]), .in_state(s[g]), .in_side(sd[g]),
         .out_valid(v[g+1]), .out_key(k[g+1]), .out_state(s[g+1]), .out_side(sd[g+1])
      );
   end

   assign out_valid = v[N];
   assign out_key   = k[N];
   assign out_block = s[N];
   assign out_side  = sd[N];
endmodule

// ===== sv/milenage_auth_functions_top.sv =====
// Milenage f1, f1*, f2-f5 and f5* over AES-128. One word is taken in every
// cycle (busy stays low); all outputs appear on rsp_* with rsp_valid high for
// exactly one cycle, after the word has passed two chains of ten round cells
// each, one registered stage for the second chain's input, and one output
// register. The receiver cannot stall, so results must be taken when shown.
// The round key is recomputed in each cell from the previous cell's key; the
// original key is carried through the first chain as a side word. OPc
// registers may be written only while no item is in flight.
module milenage_auth_functions_top #(
   parameter logic [63:0] OPC_HI_INIT = milage_pkg::OPC_HI_RESET,
   parameter logic [63:0] OPC_LO_INIT = milage_pkg::OPC_LO_RESET
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_key_hi,
   input  logic [63:0] req_key_lo,
   input  logic [63:0] req_rand_hi,
   input  logic [63:0] req_rand_lo,
   input  logic [47:0] req_sqn,
   input  logic [15:0] req_amf,
   output logic        rsp_valid,
   output logic [63:0] rsp_mac_a,
   output logic [63:0] rsp_mac_s,
   output logic [63:0] rsp_res,
   output logic [63:0] rsp_ck_hi,
   output logic [63:0] rsp_ck_lo,
   output logic [63:0] rsp_ik_hi,
   output logic [63:0] rsp_ik_lo,
   output logic [47:0] rsp_anon_key,
   output logic [47:0] rsp_anon_key_resync,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   localparam int unsigned SIDE1 = 128 + 64;

   logic [63:0] opc_hi_ff, opc_lo_ff;
   milage_pkg::block_type opc;
   assign opc = {opc_hi_ff, opc_lo_ff};

   // configuration writes
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         opc_hi_ff <= OPC_HI_INIT;
         opc_lo_ff <= OPC_LO_INIT;
      end else if (csr_valid) begin
         case (csr_index)
            milage_pkg::CSR_OPC_HI: opc_hi_ff <= csr_wdata;
            milage_pkg::CSR_OPC_LO: opc_lo_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // first pass: TEMP = E_K(RAND ^ OPc); carry key, SQN and AMF alongside
   milage_pkg::block_type [0:0] blk1;
   logic                  v1;
   milage_pkg::block_type k1, kc;
   milage_pkg::block_type [0:0] t1;
   logic [SIDE1-1:0]      sd1;
   assign blk1[0] = {req_rand_hi, req_rand_lo} ^ opc;

   milage_chain #(.NLANES(1), .SIDEW(SIDE1)) u_first (
      .clock(clock), .reset(reset), .in_valid(start),
      .in_key({req_key_hi, req_key_lo}), .in_block(blk1),
      .in_side({req_key_hi, req_key_lo, req_sqn, req_amf}),
      .out_valid(v1), .out_key(k1), .out_block(t1), .out_side(sd1)
   );

   // build the five second-pass inputs
   logic v2_ff;
   milage_pkg::block_type key2_ff;
   milage_pkg::block_type [4:0] blk2_ff, blk2_in;
   always_comb begin
      milage_pkg::block_type in1, x;
      in1 = {sd1[63:16], sd1[15:0], sd1[63:16], sd1[15:0]};
      x = t1[0] ^ opc;
      kc = sd1[SIDE1-1 -: 128];
      blk2_in[0] = t1[0] ^ {in1[63:0] ^ opc[63:0], in1[127:64] ^ opc[127:64]};
      blk2_in[1] = x ^ 128'h1;
      blk2_in[2] = {x[95:0], x[127:96]} ^ 128'h2;
      blk2_in[3] = {x[63:0], x[127:64]} ^ 128'h4;
      blk2_in[4] = {x[31:0], x[127:32]} ^ 128'h8;
   end
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1;
      key2_ff <= kc;
      blk2_ff <= blk2_in;
   end

   logic v3;
   milage_pkg::block_type k3;
   milage_pkg::block_type [4:0] o3;
   logic [0:0] sd3;
   milage_chain #(.NLANES(5), .SIDEW(1)) u_second (
      .clock(clock), .reset(reset), .in_valid(v2_ff),
      .in_key(key2_ff), .in_block(blk2_ff), .in_side(k1[0]),
      .out_valid(v3), .out_key(k3), .out_block(o3), .out_side(sd3)
   );

   // output register
   logic vo_ff;
   milage_pkg::block_type [4:0] out_ff;
   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else       vo_ff <= v3 & (k3[0] | ~k3[0]) & (sd3[0] | ~sd3[0]);
      for (int l = 0; l < 5; l++) out_ff[l] <= o3[l] ^ opc;
   end

   assign rsp_valid           = vo_ff;
   assign rsp_mac_a           = out_ff[0][127:64];
   assign rsp_mac_s           = out_ff[0][63:0];
   assign rsp_res             = out_ff[1][63:0];
   assign rsp_ck_hi           = out_ff[2][127:64];
   assign rsp_ck_lo           = out_ff[2][63:0];
   assign rsp_ik_hi           = out_ff[3][127:64];
   assign rsp_ik_lo           = out_ff[3][63:0];
   assign rsp_anon_key        = out_ff[1][127:80];
   assign rsp_anon_key_resync = out_ff[4][127:80];
endmodule
